// ===== design/rej_pkg.sv =====
// Shared types and constants for the rotary encoder jog velocity core.
package rej_pkg;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_MS = 2'd0,
    REG_DECAY_MS    = 2'd1,
    REG_STEP_ADD    = 2'd2,
    REG_DECAY_STEP  = 2'd3
  } reg_index_t;

  typedef logic signed [1:0] dir_t;

  localparam dir_t DIR_NONE = 2'sb00;
  localparam dir_t DIR_POS  = 2'sb01;
  localparam dir_t DIR_NEG  = 2'sb11;

  localparam logic [1:0] PINS_LOW  = 2'b00;
  localparam logic [1:0] PINS_HIGH = 2'b11;

  localparam int CFG_DATA_BITS = 12;
  localparam int TIMER_BITS    = 8;
  localparam int JOG_BITS      = 11;
  localparam int JOG_MAX       = 1023;
  localparam int JOG_MIN       = -1024;

  localparam logic [TIMER_BITS-1:0] TIMER_SAT = 8'hFF;

  localparam logic [7:0]  DEBOUNCE_MS_RST = 8'd2;
  localparam logic [7:0]  DECAY_MS_RST    = 8'd6;
  localparam logic [11:0] STEP_ADD_RST    = 12'h01C;
  localparam logic [11:0] DECAY_STEP_RST  = 12'd2;

endpackage

// ===== design/rotary_encoder_jog_velocity_core.sv =====
// Quadrature encoder decoder with debounce, jog magnitude and decay, one item per tick.
// Each accepted input item has its result in the output register in the following cycle.
// Throughput: one item per cycle; the single output register sets this figure, and the
// input is stalled only while that register holds a result that is itself stalled.
// Reset: synchronous active-low rst_n clears decoder state, timers, magnitude and
// direction, and loads the configuration registers with their default values.
module rotary_encoder_jog_velocity_core #(
  parameter int MAGNITUDE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_index,
  input  logic [rej_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_pin_a,
  input  logic                                  in_pin_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [1:0]                     out_step_dir,
  output logic signed [1:0]                     out_half_step_dir,
  output logic signed [rej_pkg::JOG_BITS-1:0]   out_jog_value
);

  localparam int SUM_BITS = ((MAGNITUDE_BITS > rej_pkg::CFG_DATA_BITS) ?
                             MAGNITUDE_BITS : rej_pkg::CFG_DATA_BITS) + 1;
  localparam int JW = (MAGNITUDE_BITS + 2 > rej_pkg::JOG_BITS + 1) ?
                      MAGNITUDE_BITS + 2 : rej_pkg::JOG_BITS + 1;
  localparam logic [SUM_BITS-1:0] MAG_MAX =
    SUM_BITS'((64'd1 << MAGNITUDE_BITS) - 64'd1);
  localparam logic signed [JW-1:0] JMAX = JW'(rej_pkg::JOG_MAX);
  localparam logic signed [JW-1:0] JMIN = JW'(rej_pkg::JOG_MIN);

  logic [7:0]                            debounce_ms_r;
  logic [7:0]                            decay_ms_r;
  logic [11:0]                           step_add_r;
  logic [11:0]                           decay_step_r;

  logic [1:0]                            prev_pins_r, prev_pins_nxt;
  logic                                  first_seen_r;
  logic [rej_pkg::TIMER_BITS-1:0]        debounce_count_r, debounce_count_nxt;
  logic [rej_pkg::TIMER_BITS-1:0]        decay_count_r, decay_count_nxt;
  logic [MAGNITUDE_BITS-1:0]             jog_magnitude_r, jog_magnitude_nxt;
  rej_pkg::dir_t                         last_dir_r, last_dir_nxt;

  logic                                  out_valid_r;
  rej_pkg::dir_t                         step_dir_r, step_dir_nxt;
  rej_pkg::dir_t                         half_dir_r, half_dir_nxt;
  logic signed [rej_pkg::JOG_BITS-1:0]   jog_value_r, jog_value_nxt;

  logic                                  in_accept;
  logic [1:0]                            pins;
  logic [1:0]                            prev_eff;
  logic [rej_pkg::TIMER_BITS-1:0]        debounce_inc;
  logic [rej_pkg::TIMER_BITS-1:0]        decay_inc;
  logic                                  debounce_exp;
  logic                                  pins_moved;
  logic [SUM_BITS-1:0]                   mag_ext;
  logic [SUM_BITS-1:0]                   mag_sum;
  logic [SUM_BITS-1:0]                   decay_ext;
  logic signed [JW-1:0]                  mag_signed;
  logic signed [JW-1:0]                  prod;
  logic signed [JW-1:0]                  shifted;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_step_dir      = step_dir_r;
  assign out_half_step_dir = half_dir_r;
  assign out_jog_value     = jog_value_r;

  always_comb begin
    pins     = {in_pin_b, in_pin_a};
    prev_eff = first_seen_r ? prev_pins_r : pins;

    debounce_inc = (debounce_count_r == rej_pkg::TIMER_SAT) ? rej_pkg::TIMER_SAT :
                   debounce_count_r + 1'b1;
    decay_inc    = (decay_count_r == rej_pkg::TIMER_SAT) ? rej_pkg::TIMER_SAT :
                   decay_count_r + 1'b1;

    debounce_exp = (debounce_inc >= debounce_ms_r);
    pins_moved   = debounce_exp && (prev_eff != pins);

    step_dir_nxt = rej_pkg::DIR_NONE;
    half_dir_nxt = rej_pkg::DIR_NONE;
    if (pins_moved) begin
      if (prev_eff == rej_pkg::PINS_HIGH) begin
        step_dir_nxt = in_pin_a ? rej_pkg::DIR_POS : rej_pkg::DIR_NEG;
        half_dir_nxt = step_dir_nxt;
      end else if (prev_eff == rej_pkg::PINS_LOW) begin
        step_dir_nxt = in_pin_b ? rej_pkg::DIR_POS : rej_pkg::DIR_NEG;
      end
    end

    prev_pins_nxt      = pins_moved ? pins : prev_eff;
    debounce_count_nxt = debounce_exp ? '0 : debounce_inc;

    mag_ext   = SUM_BITS'(jog_magnitude_r);
    mag_sum   = mag_ext + SUM_BITS'(step_add_r);
    decay_ext = SUM_BITS'(decay_step_r);

    jog_magnitude_nxt = jog_magnitude_r;
    decay_count_nxt   = decay_inc;
    last_dir_nxt      = last_dir_r;
    if (step_dir_nxt != rej_pkg::DIR_NONE) begin
      jog_magnitude_nxt = (mag_sum > MAG_MAX) ? MAG_MAX[MAGNITUDE_BITS-1:0] :
                          mag_sum[MAGNITUDE_BITS-1:0];
      last_dir_nxt      = step_dir_nxt;
    end else if (decay_inc >= decay_ms_r) begin
      decay_count_nxt   = '0;
      jog_magnitude_nxt = (mag_ext > decay_ext) ? MAGNITUDE_BITS'(mag_ext - decay_ext) : '0;
    end

    mag_signed = signed'(JW'(jog_magnitude_nxt));
    case (last_dir_nxt)
      rej_pkg::DIR_POS: prod = mag_signed;
      rej_pkg::DIR_NEG: prod = -mag_signed;
      default:          prod = '0;
    endcase
    shifted = prod >>> 2;

    if (shifted > JMAX) begin
      jog_value_nxt = JMAX[rej_pkg::JOG_BITS-1:0];
    end else if (shifted < JMIN) begin
      jog_value_nxt = JMIN[rej_pkg::JOG_BITS-1:0];
    end else begin
      jog_value_nxt = shifted[rej_pkg::JOG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= rej_pkg::DEBOUNCE_MS_RST;
      decay_ms_r    <= rej_pkg::DECAY_MS_RST;
      step_add_r    <= rej_pkg::STEP_ADD_RST;
      decay_step_r  <= rej_pkg::DECAY_STEP_RST;
    end else if (cfg_wr_en) begin
      case (rej_pkg::reg_index_t'(cfg_index))
        rej_pkg::REG_DEBOUNCE_MS: debounce_ms_r <= cfg_data[7:0];
        rej_pkg::REG_DECAY_MS:    decay_ms_r    <= cfg_data[7:0];
        rej_pkg::REG_STEP_ADD:    step_add_r    <= cfg_data[11:0];
        rej_pkg::REG_DECAY_STEP:  decay_step_r  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r      <= '0;
      first_seen_r     <= 1'b0;
      debounce_count_r <= '0;
      decay_count_r    <= '0;
      jog_magnitude_r  <= '0;
      last_dir_r       <= rej_pkg::DIR_NONE;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        prev_pins_r      <= prev_pins_nxt;
        first_seen_r     <= 1'b1;
        debounce_count_r <= debounce_count_nxt;
        decay_count_r    <= decay_count_nxt;
        jog_magnitude_r  <= jog_magnitude_nxt;
        last_dir_r       <= last_dir_nxt;
        out_valid_r      <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      step_dir_r  <= step_dir_nxt;
      half_dir_r  <= half_dir_nxt;
      jog_value_r <= jog_value_nxt;
    end
  end

  a_half_matches_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (half_dir_r != rej_pkg::DIR_NONE) |-> (half_dir_r == step_dir_r))
    else $error("half step direction disagrees with full step direction");

  a_first_item_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !first_seen_r |=> (step_dir_r == rej_pkg::DIR_NONE))
    else $error("first item produced a step");

  a_jog_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (jog_value_r < 0) |-> (last_dir_r == rej_pkg::DIR_NEG))
    else $error("negative jog value without negative direction");

  a_step_sets_dir: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (step_dir_nxt != rej_pkg::DIR_NONE) |=> (last_dir_r == step_dir_r))
    else $error("last direction not updated by step");

endmodule

// ===== tb/rej_jog_scoreboard_pkg.sv =====
// Scoreboard class with the jog velocity predictor for the rotary encoder core testbench.
`timescale 1ns / 100ps
package rej_jog_scoreboard_pkg;

  typedef struct packed {
    rej_pkg::dir_t                         step_dir;
    rej_pkg::dir_t                         half_step_dir;
    logic signed [rej_pkg::JOG_BITS-1:0]   jog_value;
  } jog_result_t;

  class jog_scoreboard;
    logic [7:0]     debounce_ms;
    logic [7:0]     decay_ms;
    logic [11:0]    step_add;
    logic [11:0]    decay_step;

    logic [1:0]     prev_pins;
    bit             first_seen;
    logic [7:0]     debounce_count;
    logic [7:0]     decay_count;
    logic [11:0]    magnitude;
    rej_pkg::dir_t  last_dir;

    jog_result_t    expected_q[$];
    int             mismatches;
    int             results_checked;
    int             items_noted;
    int             steps_expected;

    function new();
      debounce_ms    = rej_pkg::DEBOUNCE_MS_RST;
      decay_ms       = rej_pkg::DECAY_MS_RST;
      step_add       = rej_pkg::STEP_ADD_RST;
      decay_step     = rej_pkg::DECAY_STEP_RST;
      prev_pins      = rej_pkg::PINS_LOW;
      first_seen     = 1'b0;
      debounce_count = '0;
      decay_count    = '0;
      magnitude      = '0;
      last_dir       = rej_pkg::DIR_NONE;
      mismatches      = 0;
      results_checked = 0;
      items_noted     = 0;
      steps_expected  = 0;
    endfunction

    function void set_reg(rej_pkg::reg_index_t idx, logic [11:0] value);
      case (idx)
        rej_pkg::REG_DEBOUNCE_MS: debounce_ms = value[7:0];
        rej_pkg::REG_DECAY_MS:    decay_ms    = value[7:0];
        rej_pkg::REG_STEP_ADD:    step_add    = value;
        rej_pkg::REG_DECAY_STEP:  decay_step  = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic pin_a, logic pin_b);
      logic [1:0]     pins;
      rej_pkg::dir_t  dir;
      rej_pkg::dir_t  half;
      logic [12:0]    sum;
      int             mag_int;
      int             dir_int;
      int             jog;
      jog_result_t    res;
      pins = {pin_b, pin_a};
      dir  = rej_pkg::DIR_NONE;
      half = rej_pkg::DIR_NONE;
      if (!first_seen) begin
        prev_pins  = pins;
        first_seen = 1'b1;
      end
      if (debounce_count != rej_pkg::TIMER_SAT) debounce_count = debounce_count + 8'd1;
      if (decay_count != rej_pkg::TIMER_SAT) decay_count = decay_count + 8'd1;
      if (debounce_count >= debounce_ms) begin
        debounce_count = '0;
        if (prev_pins != pins) begin
          if (prev_pins == rej_pkg::PINS_HIGH) begin
            dir  = pin_a ? rej_pkg::DIR_POS : rej_pkg::DIR_NEG;
            half = dir;
          end else if (prev_pins == rej_pkg::PINS_LOW) begin
            dir = pin_b ? rej_pkg::DIR_POS : rej_pkg::DIR_NEG;
          end
          prev_pins = pins;
        end
      end
      if (dir != rej_pkg::DIR_NONE) begin
        sum       = {1'b0, magnitude} + {1'b0, step_add};
        magnitude = sum[12] ? 12'hFFF : sum[11:0];
        last_dir  = dir;
        steps_expected++;
      end else if (decay_count >= decay_ms) begin
        decay_count = '0;
        magnitude   = (magnitude > decay_step) ? magnitude - decay_step : 12'd0;
      end
      mag_int = magnitude;
      dir_int = last_dir;
      jog = (mag_int * dir_int) >>> 2;
      if (jog > rej_pkg::JOG_MAX) jog = rej_pkg::JOG_MAX;
      if (jog < rej_pkg::JOG_MIN) jog = rej_pkg::JOG_MIN;
      res.step_dir      = dir;
      res.half_step_dir = half;
      res.jog_value     = jog[rej_pkg::JOG_BITS-1:0];
      expected_q.push_back(res);
      items_noted++;
    endfunction

    function void check_result(rej_pkg::dir_t step_dir, rej_pkg::dir_t half_step_dir,
                               logic signed [rej_pkg::JOG_BITS-1:0] jog_value);
      jog_result_t exp_res;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result %0d: step %0d half %0d jog %0d with nothing pending",
                   results_checked, step_dir, half_step_dir, jog_value);
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.step_dir !== step_dir || exp_res.half_step_dir !== half_step_dir ||
          exp_res.jog_value !== jog_value) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d: expected step %0d half %0d jog %0d",
                   results_checked, exp_res.step_dir, exp_res.half_step_dir,
                   exp_res.jog_value);
          $display("  got step %0d half %0d jog %0d", step_dir, half_step_dir, jog_value);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/rotary_encoder_jog_velocity_core_tb.sv =====
// Top-level testbench that drives encoder pin items and register settings into the jog core.
`timescale 1ns / 100ps
module rotary_encoder_jog_velocity_core_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [7:0] QUAD_ORDER = 8'b10_11_01_00;

  logic                                  clk = 1'b0;
  logic                                  rst_n;
  logic                                  cfg_wr_en;
  logic [1:0]                            cfg_index;
  logic [rej_pkg::CFG_DATA_BITS-1:0]     cfg_data;
  logic                                  in_valid;
  logic                                  in_stall;
  logic                                  in_pin_a;
  logic                                  in_pin_b;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [1:0]                     out_step_dir;
  logic signed [1:0]                     out_half_step_dir;
  logic signed [rej_pkg::JOG_BITS-1:0]   out_jog_value;

  rej_jog_scoreboard_pkg::jog_scoreboard sb;
  bit            quiet;
  int            stall_left = 0;
  int            cycle_count = 0;
  int            settings_used;

  rotary_encoder_jog_velocity_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pin_a          (in_pin_a),
    .in_pin_b          (in_pin_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_step_dir      (out_step_dir),
    .out_half_step_dir (out_half_step_dir),
    .out_jog_value     (out_jog_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_step_dir, out_half_step_dir, out_jog_value);
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic pin_a, input logic pin_b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pin_a <= pin_a;
    in_pin_b <= pin_b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(pin_a, pin_b);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic put_reg(input rej_pkg::reg_index_t idx, input logic [11:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] debounce, input logic [7:0] decay,
                                input logic [11:0] add, input logic [11:0] shrink);
    wait_drained();
    put_reg(rej_pkg::REG_DEBOUNCE_MS, {4'd0, debounce});
    put_reg(rej_pkg::REG_DECAY_MS, {4'd0, decay});
    put_reg(rej_pkg::REG_STEP_ADD, add);
    put_reg(rej_pkg::REG_DECAY_STEP, shrink);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // Mostly a clean quadrature walk, each position held for 1 to 2*span items, where span
  // is the debounce period clamped to 1..4, with occasional reversals and single-item glitches on random pins.
  task automatic walk_encoder(input int count, input int debounce);
    int         produced;
    int         span;
    int         pos;
    int         heading;
    int         hold;
    int         k;
    logic [1:0] pins;
    span = (debounce == 0) ? 1 : ((debounce > 4) ? 4 : debounce);
    produced = 0;
    pos = 0;
    heading = 1;
    while (produced < count) begin
      if ($urandom_range(0, 9) == 0) begin
        pins = 2'($urandom_range(0, 3));
        send_item(pins[0], pins[1]);
        produced++;
      end else begin
        if ($urandom_range(0, 7) == 0) heading = -heading;
        pos = (pos + heading + 4) % 4;
        pins = QUAD_ORDER[pos*2 +: 2];
        hold = $urandom_range(1, 2 * span);
        for (k = 0; k < hold && produced < count; k++) begin
          send_item(pins[0], pins[1]);
          produced++;
        end
      end
    end
  endtask

  initial begin
    logic [1:0] directed_pins [24];
    int         i;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = rej_pkg::REG_DEBOUNCE_MS;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_pin_a    = 1'b0;
    in_pin_b    = 1'b0;
    quiet       = 1'b0;
    settings_used = 1;
    sb = new();
    directed_pins = '{2'd3, 2'd3, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2,
                      2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd3, 2'd3, 2'd0, 2'd0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < 24; i++) send_item(directed_pins[i][0], directed_pins[i][1]);
    walk_encoder(50, int'(rej_pkg::DEBOUNCE_MS_RST));

    apply_settings(8'd1, 8'd1, 12'hFFF, 12'hFFF);
    walk_encoder(35, 1);
    wait_drained();
    walk_encoder(35, 1);

    apply_settings(8'd255, 8'd255, 12'd0, 12'd0);
    walk_encoder(70, 255);

    apply_settings(8'd0, 8'd0, 12'd1000, 12'd1);
    quiet = 1'b1;
    walk_encoder(60, 0);
    quiet = 1'b0;

    repeat (3) begin
      apply_settings(8'($urandom_range(1, 5)), 8'($urandom_range(1, 30)),
                     12'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 200)
                                                     : $urandom_range(0, 4095)),
                     12'($urandom_range(0, 300)));
      walk_encoder(60, 5);
    end

    wait_drained();
    repeat (4) @(negedge clk);
    $display("Covered %0d pin items under %0d register settings, including zero and full-scale",
             sb.items_noted, settings_used);
    $display("timer periods and saturating magnitudes; %0d results checked, %0d with a step.",
             sb.results_checked, sb.steps_expected);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
